### hw/rtl/mips_subset_single_cycle_core_unit_macros.svh
// ----------------------------------------------------------------------------
// mips subset core assertion macros
// same-cycle and next-cycle implication checks on the core clock
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_UNIT_MACROS_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_UNIT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define MSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("core check failed");

// antecedent holds, consequent holds in the next cycle
`define MSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("core check failed");

`endif

### hw/rtl/mips_sc_pkg.sv
// ----------------------------------------------------------------------------
// mips subset core package
// request and response words, decode constants and the execute result
// ----------------------------------------------------------------------------
package mips_sc_pkg;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_EXEC = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [31:0] HALT_PC = 32'hffffffff;
  localparam logic [31:0] SP_INIT = 32'h00100000;
  localparam logic [31:0] JMP_REGION_MASK = 32'hf0000000;
  localparam logic [4:0]  REG_ZERO = 5'd0;
  localparam logic [4:0]  REG_SP = 5'd29;
  localparam logic [4:0]  REG_RA = 5'd31;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  localparam int NUM_CNT  = 6;
  localparam int CNT_EXEC = 0;
  localparam int CNT_R    = 1;
  localparam int CNT_I    = 2;
  localparam int CNT_J    = 3;
  localparam int CNT_MEM  = 4;
  localparam int CNT_BR   = 5;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] word_address;
    logic [31:0] load_data;
    logic [4:0]  register_index;
  } req_t;

  typedef struct packed {
    logic [31:0] program_counter;
    logic        halted;
    logic [31:0] register_value;
    logic [31:0] executed_count;
    logic [31:0] rtype_count;
    logic [31:0] itype_count;
    logic [31:0] jtype_count;
    logic [31:0] memory_access_count;
    logic [31:0] branch_count;
    logic        bad_opcode;
  } rsp_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_we;
    logic [4:0]  reg_idx;
    logic [31:0] reg_data;
    logic        mem_we;
    logic        mem_load;
    logic [31:0] mem_addr;
    logic [31:0] store_data;
    logic        cnt_r;
    logic        cnt_i;
    logic        cnt_j;
    logic        cnt_mem;
    logic        cnt_br;
    logic        bad;
  } ex_t;

endpackage

### hw/rtl/mips_subset_single_cycle_core_unit.sv
// ----------------------------------------------------------------------------
// mips subset single-cycle core
// executes one instruction per request from a unified word memory
// ----------------------------------------------------------------------------
// Requests arrive on req (req_valid, req_stall): load a memory word, execute
// the instruction at the pc, or read a register. Each request gives exactly
// one response on rsp (rsp_valid, rsp_stall) with the pc, halt flag, register
// value read, six statistics counters and an unsupported-instruction flag.
// Except for lw, the response is registered and shows in the cycle after its
// request is taken. Throughput is one request per cycle while no lw is pending
// and the response is not stalled; an lw's data comes through the registered
// data read port of the memory, and the request side stalls until it is
// written back. The next instruction is always prefetched from the memory
// fetch port, with same-cycle write forwarding, so no fetch wait is needed.
// The response register holds while rsp_stall is high; a new request is
// taken in the cycle the response leaves, so a stalled receiver stalls req.
// Reset clears the pc and counters, loads the registers (r29 stack pointer,
// r31 all ones) and drops rsp_valid; memory is not cleared. MEM_WORDS must be
// a power of two; addresses wrap to its size.
// ----------------------------------------------------------------------------
`include "mips_subset_single_cycle_core_unit_macros.svh"

module mips_subset_single_cycle_core_unit #(
  parameter int MEM_WORDS = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mips_sc_pkg::req_t   req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mips_sc_pkg::rsp_t   rsp
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [31:0]      pc;
  logic [31:0]      pc_next;
  logic [31:0]      regs [32];
  logic [31:0]      cnt [mips_sc_pkg::NUM_CNT];
  logic [31:0]      cnt_next [mips_sc_pkg::NUM_CNT];
  logic             lw_pend;
  logic [4:0]       lw_rt;
  logic             accept;
  logic             is_exec;
  logic             lw_done;
  logic             rsp_free;
  logic [31:0]      ir;
  logic [31:0]      rd_data;
  logic [31:0]      op_a;
  logic [31:0]      op_b;
  logic [31:0]      load_word;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [31:0]      wr_data;
  logic             rd_en;
  mips_sc_pkg::ex_t ex;

  assign rsp_free  = !(rsp_valid && rsp_stall);
  assign req_stall = lw_pend || !rsp_free;
  assign accept    = req_valid && !req_stall;
  assign is_exec   = accept && (req.action == mips_sc_pkg::ACT_EXEC)
                     && (pc != mips_sc_pkg::HALT_PC);
  assign lw_done   = lw_pend && rsp_free;

  assign op_a = regs[ir[25:21]];
  assign op_b = regs[ir[20:16]];

  mips_sc_exec u_exec (
    .pc (pc),
    .ir (ir),
    .a  (op_a),
    .b  (op_b),
    .ex (ex)
  );

  assign pc_next   = is_exec ? ex.next_pc : pc;
  assign load_word = {16'b0, req.word_address};

  always_comb begin
    if (accept && (req.action == mips_sc_pkg::ACT_LOAD)) begin
      wr_en   = 1'b1;
      wr_addr = load_word[AW-1:0];
      wr_data = req.load_data;
    end else begin
      wr_en   = is_exec && ex.mem_we;
      wr_addr = ex.mem_addr[AW+1:2];
      wr_data = ex.store_data;
    end
  end

  assign rd_en = is_exec && ex.mem_load;

  mips_sc_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk        (clk),
    .fetch_addr (pc_next[AW+1:2]),
    .fetch_data (ir),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (ex.mem_addr[AW+1:2]),
    .rd_data    (rd_data)
  );

  always_comb begin
    cnt_next[mips_sc_pkg::CNT_EXEC] = cnt[mips_sc_pkg::CNT_EXEC] + {31'b0, is_exec};
    cnt_next[mips_sc_pkg::CNT_R]    = cnt[mips_sc_pkg::CNT_R] + {31'b0, is_exec && ex.cnt_r};
    cnt_next[mips_sc_pkg::CNT_I]    = cnt[mips_sc_pkg::CNT_I] + {31'b0, is_exec && ex.cnt_i};
    cnt_next[mips_sc_pkg::CNT_J]    = cnt[mips_sc_pkg::CNT_J] + {31'b0, is_exec && ex.cnt_j};
    cnt_next[mips_sc_pkg::CNT_MEM]  = cnt[mips_sc_pkg::CNT_MEM]
                                      + {31'b0, is_exec && ex.cnt_mem};
    cnt_next[mips_sc_pkg::CNT_BR]   = cnt[mips_sc_pkg::CNT_BR]
                                      + {31'b0, is_exec && ex.cnt_br};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      lw_pend   <= 1'b0;
      rsp_valid <= 1'b0;
      for (int k = 0; k < mips_sc_pkg::NUM_CNT; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      pc <= pc_next;
      for (int k = 0; k < mips_sc_pkg::NUM_CNT; k++) begin
        cnt[k] <= cnt_next[k];
      end
      if (rd_en) begin
        lw_pend <= 1'b1;
      end else if (lw_done) begin
        lw_pend <= 1'b0;
      end
      if ((accept && !rd_en) || lw_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_free) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 32; k++) begin
        regs[k] <= '0;
      end
      regs[mips_sc_pkg::REG_SP] <= mips_sc_pkg::SP_INIT;
      regs[mips_sc_pkg::REG_RA] <= mips_sc_pkg::HALT_PC;
    end else if (lw_done) begin
      if (lw_rt != mips_sc_pkg::REG_ZERO) begin
        regs[lw_rt] <= rd_data;
      end
    end else if (is_exec && ex.reg_we && (ex.reg_idx != mips_sc_pkg::REG_ZERO)) begin
      regs[ex.reg_idx] <= ex.reg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      lw_rt <= ir[20:16];
    end
  end

  always_ff @(posedge clk) begin
    if ((accept && !rd_en) || lw_done) begin
      rsp.program_counter     <= pc_next;
      rsp.halted              <= (pc_next == mips_sc_pkg::HALT_PC);
      rsp.register_value      <= (accept && (req.action == mips_sc_pkg::ACT_READ))
                                 ? regs[req.register_index] : '0;
      rsp.executed_count      <= cnt_next[mips_sc_pkg::CNT_EXEC];
      rsp.rtype_count         <= cnt_next[mips_sc_pkg::CNT_R];
      rsp.itype_count         <= cnt_next[mips_sc_pkg::CNT_I];
      rsp.jtype_count         <= cnt_next[mips_sc_pkg::CNT_J];
      rsp.memory_access_count <= cnt_next[mips_sc_pkg::CNT_MEM];
      rsp.branch_count        <= cnt_next[mips_sc_pkg::CNT_BR];
      rsp.bad_opcode          <= is_exec && ex.bad;
    end
  end

  // lw parks the request side until its data is written back
  `MSC_ASSERT_NEXT(a_lw_pends, rd_en, lw_pend && !rsp_valid)
  `MSC_ASSERT_NOW(a_pend_stalls, lw_pend, req_stall)
  `MSC_ASSERT_NEXT(a_lw_done_rsp, lw_done, rsp_valid && !lw_pend)
  `MSC_ASSERT_NOW(a_r0_zero, 1'b1, regs[0] == 32'd0)
  `MSC_ASSERT_NEXT(a_accept_rsp, accept && !rd_en, rsp_valid)

endmodule

### hw/rtl/mips_sc_exec.sv
// ----------------------------------------------------------------------------
// mips subset execute unit
// decodes one instruction and computes next pc, writeback and memory access
// ----------------------------------------------------------------------------
module mips_sc_exec (
  input  logic [31:0]       pc,
  input  logic [31:0]       ir,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output mips_sc_pkg::ex_t  ex
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] zimm;
  logic [31:0] simm;
  logic [31:0] seq_pc;

  assign op     = ir[31:26];
  assign fn     = ir[5:0];
  assign rt     = ir[20:16];
  assign rd     = ir[15:11];
  assign sh     = ir[10:6];
  assign zimm   = {16'b0, ir[15:0]};
  assign simm   = {{16{ir[15]}}, ir[15:0]};
  assign seq_pc = pc + 32'd4;

  always_comb begin
    ex            = '0;
    ex.next_pc    = seq_pc;
    ex.reg_idx    = rt;
    ex.mem_addr   = a + simm;
    ex.store_data = b;
    unique case (op)
      mips_sc_pkg::OP_SPECIAL: begin
        ex.cnt_r   = 1'b1;
        ex.reg_we  = 1'b1;
        ex.reg_idx = rd;
        unique case (fn)
          mips_sc_pkg::FN_ADD, mips_sc_pkg::FN_ADDU: ex.reg_data = a + b;
          mips_sc_pkg::FN_SUB, mips_sc_pkg::FN_SUBU: ex.reg_data = a - b;
          mips_sc_pkg::FN_AND:  ex.reg_data = a & b;
          mips_sc_pkg::FN_OR:   ex.reg_data = a | b;
          mips_sc_pkg::FN_NOR:  ex.reg_data = ~(a | b);
          mips_sc_pkg::FN_SLT:  ex.reg_data = {31'b0, $signed(a) < $signed(b)};
          mips_sc_pkg::FN_SLTU: ex.reg_data = {31'b0, a < b};
          mips_sc_pkg::FN_SLL:  ex.reg_data = b << sh;
          mips_sc_pkg::FN_SRL:  ex.reg_data = b >> sh;
          mips_sc_pkg::FN_JR: begin
            ex.reg_we  = 1'b0;
            ex.next_pc = a;
          end
          default: begin
            ex.reg_we = 1'b0;
            ex.cnt_r  = 1'b0;
            ex.bad    = 1'b1;
          end
        endcase
      end
      mips_sc_pkg::OP_J: begin
        ex.cnt_j   = 1'b1;
        ex.next_pc = (seq_pc & mips_sc_pkg::JMP_REGION_MASK) | {4'b0, ir[25:0], 2'b00};
      end
      mips_sc_pkg::OP_JAL: begin
        ex.cnt_j    = 1'b1;
        ex.next_pc  = (seq_pc & mips_sc_pkg::JMP_REGION_MASK) | {4'b0, ir[25:0], 2'b00};
        ex.reg_we   = 1'b1;
        ex.reg_idx  = mips_sc_pkg::REG_RA;
        ex.reg_data = pc + 32'd8;
      end
      mips_sc_pkg::OP_ADDI, mips_sc_pkg::OP_ADDIU: begin
        ex.cnt_i    = 1'b1;
        ex.reg_we   = 1'b1;
        ex.reg_data = a + simm;
      end
      mips_sc_pkg::OP_ANDI: begin
        ex.cnt_i    = 1'b1;
        ex.reg_we   = 1'b1;
        ex.reg_data = a & zimm;
      end
      mips_sc_pkg::OP_ORI: begin
        ex.cnt_i    = 1'b1;
        ex.reg_we   = 1'b1;
        ex.reg_data = a | zimm;
      end
      mips_sc_pkg::OP_LUI: begin
        ex.cnt_i    = 1'b1;
        ex.reg_we   = 1'b1;
        ex.reg_data = {ir[15:0], 16'b0};
      end
      mips_sc_pkg::OP_SLTI: begin
        ex.cnt_i    = 1'b1;
        ex.reg_we   = 1'b1;
        ex.reg_data = {31'b0, $signed(a) < $signed(simm)};
      end
      mips_sc_pkg::OP_LW: begin
        ex.cnt_i    = 1'b1;
        ex.cnt_mem  = 1'b1;
        ex.mem_load = 1'b1;
      end
      mips_sc_pkg::OP_SW: begin
        ex.cnt_i   = 1'b1;
        ex.cnt_mem = 1'b1;
        ex.mem_we  = 1'b1;
      end
      mips_sc_pkg::OP_BEQ, mips_sc_pkg::OP_BNE: begin
        ex.cnt_i  = 1'b1;
        ex.cnt_br = 1'b1;
        if ((op == mips_sc_pkg::OP_BEQ) == (a == b)) begin
          ex.next_pc = seq_pc + {simm[29:0], 2'b00};
        end
      end
      default: begin
        ex.bad = 1'b1;
      end
    endcase
  end

endmodule

### hw/rtl/mips_sc_mem.sv
// ----------------------------------------------------------------------------
// mips subset unified word memory
// one write port, a fetch read port with write forwarding, a data read port
// ----------------------------------------------------------------------------
module mips_sc_mem #(
  parameter int MEM_WORDS = 65536,
  localparam int AW = $clog2(MEM_WORDS)
) (
  input  logic          clk,
  input  logic [AW-1:0] fetch_addr,
  output logic [31:0]   fetch_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] ram [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == fetch_addr)) begin
      fetch_data <= wr_data;
    end else begin
      fetch_data <= ram[fetch_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ram[rd_addr];
    end
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// mips subset core testbench
// loads small programs into the core's word memory, steps them one
// instruction per request and checks every response against a local
// instruction-level model, with random bursts on the request side and random
// stalls on the response side
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_WORDS = 65536;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [5:0] OP_UNUSED = 6'h3f;
  localparam logic [5:0] FN_UNUSED = 6'h01;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  mips_sc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  mips_sc_pkg::rsp_t rsp;

  logic [31:0] arch_regs [32];
  logic [31:0] mem_img [MEM_WORDS];
  bit mem_written [MEM_WORDS];
  logic [31:0] pc_now;
  logic [31:0] stat_cnt [mips_sc_pkg::NUM_CNT];

  mips_sc_pkg::rsp_t status_due [$];
  mips_sc_pkg::rsp_t want;
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int items_sent = 0;

  mips_subset_single_cycle_core_unit #(.MEM_WORDS(MEM_WORDS)) dut (
    .clk,
    .rst,
    .req_valid,
    .req_stall,
    .req,
    .rsp_valid,
    .rsp_stall,
    .rsp
  );

  always #5ns clk = ~clk;

  function automatic logic [15:0] slot_of(logic [31:0] byte_addr);
    return 16'((byte_addr >> 2) % MEM_WORDS);
  endfunction

  function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh);
    return {mips_sc_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] target);
    return {op, target};
  endfunction

  function automatic mips_sc_pkg::ex_t decode_ins(logic [31:0] ins);
    mips_sc_pkg::ex_t e;
    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] sh;
    logic [31:0] zimm;
    logic [31:0] simm;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] seq_pc;
    op = ins[31:26];
    fn = ins[5:0];
    sh = ins[10:6];
    zimm = {16'h0000, ins[15:0]};
    simm = {{16{ins[15]}}, ins[15:0]};
    a = arch_regs[ins[25:21]];
    b = arch_regs[ins[20:16]];
    seq_pc = pc_now + 32'd4;
    e = '0;
    e.next_pc = seq_pc;
    if (op == mips_sc_pkg::OP_SPECIAL) begin
      e.cnt_r = 1'b1;
      e.reg_we = 1'b1;
      e.reg_idx = ins[15:11];
      case (fn)
        mips_sc_pkg::FN_ADD, mips_sc_pkg::FN_ADDU: e.reg_data = a + b;
        mips_sc_pkg::FN_SUB, mips_sc_pkg::FN_SUBU: e.reg_data = a - b;
        mips_sc_pkg::FN_AND: e.reg_data = a & b;
        mips_sc_pkg::FN_OR: e.reg_data = a | b;
        mips_sc_pkg::FN_NOR: e.reg_data = ~(a | b);
        mips_sc_pkg::FN_SLT: e.reg_data = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        mips_sc_pkg::FN_SLTU: e.reg_data = (a < b) ? 32'd1 : 32'd0;
        mips_sc_pkg::FN_SLL: e.reg_data = b << sh;
        mips_sc_pkg::FN_SRL: e.reg_data = b >> sh;
        mips_sc_pkg::FN_JR: begin
          e.reg_we = 1'b0;
          e.next_pc = a;
        end
        default: begin
          e.cnt_r = 1'b0;
          e.reg_we = 1'b0;
          e.bad = 1'b1;
        end
      endcase
    end else if (op == mips_sc_pkg::OP_J || op == mips_sc_pkg::OP_JAL) begin
      e.cnt_j = 1'b1;
      e.next_pc = (seq_pc & mips_sc_pkg::JMP_REGION_MASK) | {4'd0, ins[25:0], 2'd0};
      if (op == mips_sc_pkg::OP_JAL) begin
        e.reg_we = 1'b1;
        e.reg_idx = mips_sc_pkg::REG_RA;
        e.reg_data = pc_now + 32'd8;
      end
    end else begin
      e.cnt_i = 1'b1;
      e.reg_we = 1'b1;
      e.reg_idx = ins[20:16];
      case (op)
        mips_sc_pkg::OP_ADDI, mips_sc_pkg::OP_ADDIU: e.reg_data = a + simm;
        mips_sc_pkg::OP_ANDI: e.reg_data = a & zimm;
        mips_sc_pkg::OP_ORI: e.reg_data = a | zimm;
        mips_sc_pkg::OP_LUI: e.reg_data = zimm << 16;
        mips_sc_pkg::OP_SLTI: e.reg_data = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
        mips_sc_pkg::OP_LW: begin
          e.cnt_mem = 1'b1;
          e.mem_load = 1'b1;
          e.mem_addr = a + simm;
          e.reg_data = mem_img[slot_of(a + simm)];
        end
        mips_sc_pkg::OP_SW: begin
          e.cnt_mem = 1'b1;
          e.reg_we = 1'b0;
          e.mem_we = 1'b1;
          e.mem_addr = a + simm;
          e.store_data = b;
        end
        mips_sc_pkg::OP_BEQ, mips_sc_pkg::OP_BNE: begin
          e.cnt_br = 1'b1;
          e.reg_we = 1'b0;
          if ((op == mips_sc_pkg::OP_BEQ) == (a == b)) e.next_pc = seq_pc + (simm << 2);
        end
        default: begin
          e.cnt_i = 1'b0;
          e.reg_we = 1'b0;
          e.bad = 1'b1;
        end
      endcase
    end
    if (e.reg_idx == mips_sc_pkg::REG_ZERO) e.reg_we = 1'b0;
    return e;
  endfunction

  function automatic mips_sc_pkg::rsp_t core_step(mips_sc_pkg::req_t r);
    mips_sc_pkg::rsp_t s;
    mips_sc_pkg::ex_t e;
    logic [31:0] rv;
    logic bad;
    rv = '0;
    bad = 1'b0;
    case (r.action)
      mips_sc_pkg::ACT_LOAD: begin
        mem_img[r.word_address] = r.load_data;
        mem_written[r.word_address] = 1'b1;
      end
      mips_sc_pkg::ACT_EXEC: if (pc_now != mips_sc_pkg::HALT_PC) begin
        e = decode_ins(mem_img[slot_of(pc_now)]);
        if (e.reg_we) arch_regs[e.reg_idx] = e.reg_data;
        if (e.mem_we) begin
          mem_img[slot_of(e.mem_addr)] = e.store_data;
          mem_written[slot_of(e.mem_addr)] = 1'b1;
        end
        stat_cnt[mips_sc_pkg::CNT_EXEC] += 32'd1;
        stat_cnt[mips_sc_pkg::CNT_R] += 32'(e.cnt_r);
        stat_cnt[mips_sc_pkg::CNT_I] += 32'(e.cnt_i);
        stat_cnt[mips_sc_pkg::CNT_J] += 32'(e.cnt_j);
        stat_cnt[mips_sc_pkg::CNT_MEM] += 32'(e.cnt_mem);
        stat_cnt[mips_sc_pkg::CNT_BR] += 32'(e.cnt_br);
        pc_now = e.next_pc;
        bad = e.bad;
      end
      mips_sc_pkg::ACT_READ: rv = arch_regs[r.register_index];
      default: ;
    endcase
    s.program_counter = pc_now;
    s.halted = (pc_now == mips_sc_pkg::HALT_PC);
    s.register_value = rv;
    s.executed_count = stat_cnt[mips_sc_pkg::CNT_EXEC];
    s.rtype_count = stat_cnt[mips_sc_pkg::CNT_R];
    s.itype_count = stat_cnt[mips_sc_pkg::CNT_I];
    s.jtype_count = stat_cnt[mips_sc_pkg::CNT_J];
    s.memory_access_count = stat_cnt[mips_sc_pkg::CNT_MEM];
    s.branch_count = stat_cnt[mips_sc_pkg::CNT_BR];
    s.bad_opcode = bad;
    return s;
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 1) != 0) ? 5'($urandom_range(8, 15)) : 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] gen_ins();
    logic [5:0] op;
    logic [5:0] fn;
    int k;
    k = $urandom_range(0, 99);
    if (k < 30) begin
      case ($urandom_range(0, 10))
        0: fn = mips_sc_pkg::FN_ADD;
        1: fn = mips_sc_pkg::FN_ADDU;
        2: fn = mips_sc_pkg::FN_SUB;
        3: fn = mips_sc_pkg::FN_SUBU;
        4: fn = mips_sc_pkg::FN_AND;
        5: fn = mips_sc_pkg::FN_OR;
        6: fn = mips_sc_pkg::FN_NOR;
        7: fn = mips_sc_pkg::FN_SLT;
        8: fn = mips_sc_pkg::FN_SLTU;
        9: fn = mips_sc_pkg::FN_SLL;
        default: fn = mips_sc_pkg::FN_SRL;
      endcase
      return enc_r(fn, pick_reg(), pick_reg(), pick_reg(), 5'($urandom_range(0, 31)));
    end
    if (k < 50) begin
      case ($urandom_range(0, 5))
        0: op = mips_sc_pkg::OP_ADDI;
        1: op = mips_sc_pkg::OP_ADDIU;
        2: op = mips_sc_pkg::OP_SLTI;
        3: op = mips_sc_pkg::OP_ANDI;
        4: op = mips_sc_pkg::OP_ORI;
        default: op = mips_sc_pkg::OP_LUI;
      endcase
      return enc_i(op, pick_reg(), pick_reg(), 16'($urandom));
    end
    if (k < 62) begin
      op = ($urandom_range(0, 1) != 0) ? mips_sc_pkg::OP_LW : mips_sc_pkg::OP_SW;
      if ($urandom_range(0, 3) != 0)
        return enc_i(op, mips_sc_pkg::REG_SP, pick_reg(),
                     16'(int'($urandom_range(0, 128)) - 64));
      return enc_i(op, pick_reg(), pick_reg(), 16'($urandom));
    end
    if (k < 74) begin
      op = ($urandom_range(0, 1) != 0) ? mips_sc_pkg::OP_BEQ : mips_sc_pkg::OP_BNE;
      return enc_i(op, pick_reg(), pick_reg(), 16'(int'($urandom_range(0, 12)) - 4));
    end
    if (k < 86) begin
      op = ($urandom_range(0, 1) != 0) ? mips_sc_pkg::OP_J : mips_sc_pkg::OP_JAL;
      return enc_j(op, ($urandom_range(0, 7) == 0) ? 26'($urandom)
                                                    : 26'($urandom_range(0, 1023)));
    end
    if (k < 92)
      return enc_r(mips_sc_pkg::FN_JR,
                   ($urandom_range(0, 2) != 0) ? mips_sc_pkg::REG_RA : pick_reg(),
                   pick_reg(), pick_reg(), 5'($urandom_range(0, 31)));
    if (k < 96) begin
      op = 6'($urandom_range(0, 63));
      if (op inside {mips_sc_pkg::OP_SPECIAL, mips_sc_pkg::OP_J, mips_sc_pkg::OP_JAL,
                     mips_sc_pkg::OP_BEQ, mips_sc_pkg::OP_BNE, mips_sc_pkg::OP_ADDI,
                     mips_sc_pkg::OP_ADDIU, mips_sc_pkg::OP_SLTI, mips_sc_pkg::OP_ANDI,
                     mips_sc_pkg::OP_ORI, mips_sc_pkg::OP_LUI, mips_sc_pkg::OP_LW,
                     mips_sc_pkg::OP_SW}) op = OP_UNUSED;
      return {op, 26'($urandom)};
    end
    if (k < 98) begin
      fn = 6'($urandom_range(0, 63));
      if (fn inside {mips_sc_pkg::FN_SLL, mips_sc_pkg::FN_SRL, mips_sc_pkg::FN_JR,
                     mips_sc_pkg::FN_ADD, mips_sc_pkg::FN_ADDU, mips_sc_pkg::FN_SUB,
                     mips_sc_pkg::FN_SUBU, mips_sc_pkg::FN_AND, mips_sc_pkg::FN_OR,
                     mips_sc_pkg::FN_NOR, mips_sc_pkg::FN_SLT,
                     mips_sc_pkg::FN_SLTU}) fn = FN_UNUSED;
      return {mips_sc_pkg::OP_SPECIAL, 20'($urandom), fn};
    end
    return $urandom;
  endfunction

  function automatic mips_sc_pkg::req_t mk_req(logic [1:0] action);
    mips_sc_pkg::req_t r;
    r.action = action;
    r.word_address = 16'($urandom_range(0, 65535));
    r.load_data = $urandom;
    r.register_index = 5'($urandom_range(0, 31));
    return r;
  endfunction

  task automatic send_req(input mips_sc_pkg::req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
    status_due.push_back(core_step(r));
  endtask

  task automatic send_load(input logic [15:0] slot, input logic [31:0] data);
    mips_sc_pkg::req_t r;
    r = mk_req(mips_sc_pkg::ACT_LOAD);
    r.word_address = slot;
    r.load_data = data;
    send_req(r);
  endtask

  task automatic send_read(input logic [4:0] idx);
    mips_sc_pkg::req_t r;
    r = mk_req(mips_sc_pkg::ACT_READ);
    r.register_index = idx;
    send_req(r);
  endtask

  task automatic run_ins(input logic [31:0] ins);
    send_load(slot_of(pc_now), ins);
    send_req(mk_req(mips_sc_pkg::ACT_EXEC));
  endtask

  // keep the fetch and lw words defined and the core away from the halt pc
  task automatic exec_random();
    mips_sc_pkg::ex_t e;
    logic [15:0] s;
    s = slot_of(pc_now);
    if (!mem_written[s] || $urandom_range(0, 19) == 0) send_load(s, gen_ins());
    e = decode_ins(mem_img[s]);
    if (e.next_pc == mips_sc_pkg::HALT_PC) begin
      send_load(s, enc_j(mips_sc_pkg::OP_J, 26'($urandom_range(0, 1023))));
      e = decode_ins(mem_img[s]);
    end
    if (e.mem_load && !mem_written[slot_of(e.mem_addr)])
      send_load(slot_of(e.mem_addr), $urandom);
    send_req(mk_req(mips_sc_pkg::ACT_EXEC));
  endtask

  task automatic test_field_extremes();
    send_req('{action: mips_sc_pkg::ACT_LOAD, word_address: 16'hffff,
               load_data: 32'hffffffff, register_index: 5'd31});
    send_req('{action: mips_sc_pkg::ACT_LOAD, word_address: 16'h0000,
               load_data: 32'h00000000, register_index: mips_sc_pkg::REG_ZERO});
    send_req('{action: mips_sc_pkg::ACT_READ, word_address: 16'hffff,
               load_data: 32'hffffffff, register_index: mips_sc_pkg::REG_SP});
    send_req('{action: ACT_NONE, word_address: 16'hffff, load_data: 32'hffffffff,
               register_index: 5'd31});
    send_req('{action: mips_sc_pkg::ACT_EXEC, word_address: 16'h0000,
               load_data: 32'h00000000, register_index: mips_sc_pkg::REG_ZERO});
  endtask

  task automatic test_instruction_cases();
    run_ins(enc_i(mips_sc_pkg::OP_ADDI, mips_sc_pkg::REG_SP, mips_sc_pkg::REG_ZERO,
                  16'h0005));
    run_ins(enc_i(mips_sc_pkg::OP_LUI, mips_sc_pkg::REG_ZERO, 5'd8, 16'h8000));
    run_ins(enc_r(mips_sc_pkg::FN_SRL, mips_sc_pkg::REG_ZERO, 5'd8, 5'd9, 5'd31));
    run_ins(enc_r(mips_sc_pkg::FN_NOR, 5'd8, mips_sc_pkg::REG_ZERO, 5'd10, 5'd0));
    run_ins(enc_r(mips_sc_pkg::FN_SLTU, 5'd10, 5'd8, 5'd11, 5'd0));
    run_ins(enc_i(mips_sc_pkg::OP_SW, mips_sc_pkg::REG_SP, 5'd8, 16'hfffc));
    run_ins(enc_i(mips_sc_pkg::OP_LW, mips_sc_pkg::REG_SP, 5'd13, 16'hfffc));
    run_ins(enc_i(mips_sc_pkg::OP_BNE, 5'd8, mips_sc_pkg::REG_ZERO, 16'hfffe));
    run_ins(enc_j(mips_sc_pkg::OP_JAL, 26'h0000400));
    run_ins(enc_i(OP_UNUSED, 5'd8, 5'd9, 16'h1234));
    run_ins(enc_r(FN_UNUSED, 5'd8, 5'd9, 5'd10, 5'd0));
    send_read(5'd13);
    send_read(mips_sc_pkg::REG_RA);
  endtask

  task automatic test_random_program();
    int k;
    while (items_sent < RANDOM_ITEMS) begin
      k = $urandom_range(0, 99);
      if (k < 70) exec_random();
      else if (k < 82) send_req(mk_req(mips_sc_pkg::ACT_LOAD));
      else if (k < 95) send_req(mk_req(mips_sc_pkg::ACT_READ));
      else send_req(mk_req(ACT_NONE));
    end
  endtask

  task automatic test_halt();
    run_ins(enc_i(mips_sc_pkg::OP_ADDIU, mips_sc_pkg::REG_ZERO, 5'd14, 16'hffff));
    run_ins(enc_r(mips_sc_pkg::FN_JR, 5'd14, mips_sc_pkg::REG_ZERO, mips_sc_pkg::REG_ZERO,
                  5'd0));
    send_req(mk_req(mips_sc_pkg::ACT_EXEC));
    send_read(5'd14);
    send_req(mk_req(mips_sc_pkg::ACT_LOAD));
    send_req(mk_req(mips_sc_pkg::ACT_EXEC));
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (status_due.size() == 0) begin
        $error("response with no request pending");
        mismatches++;
      end else begin
        want = status_due.pop_front();
        check_field("program_counter", want.program_counter, rsp.program_counter);
        check_field("halted", 32'(want.halted), 32'(rsp.halted));
        check_field("register_value", want.register_value, rsp.register_value);
        check_field("executed_count", want.executed_count, rsp.executed_count);
        check_field("rtype_count", want.rtype_count, rsp.rtype_count);
        check_field("itype_count", want.itype_count, rsp.itype_count);
        check_field("jtype_count", want.jtype_count, rsp.jtype_count);
        check_field("memory_access_count", want.memory_access_count,
                    rsp.memory_access_count);
        check_field("branch_count", want.branch_count, rsp.branch_count);
        check_field("bad_opcode", 32'(want.bad_opcode), 32'(rsp.bad_opcode));
      end
    end
  end

  // receiver stall pattern: free, light, half and heavy stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 60);
    end
    stall_left--;
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 1) != 0);
      default: rsp_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    arch_regs[mips_sc_pkg::REG_SP] = mips_sc_pkg::SP_INIT;
    arch_regs[mips_sc_pkg::REG_RA] = mips_sc_pkg::HALT_PC;
    for (int i = 0; i < mips_sc_pkg::NUM_CNT; i++) stat_cnt[i] = '0;
    pc_now = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_instruction_cases();
    test_random_program();
    test_halt();
    req_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/mips_sc_pkg.sv
hw/rtl/mips_sc_exec.sv
hw/rtl/mips_sc_mem.sv
hw/rtl/mips_subset_single_cycle_core_unit.sv
tb/tb.sv
